[sv/ffpa_pkg.sv]
// Shared constants and controller/datapath interface types for the page run allocator.
package ffpa_pkg;

	localparam int PAGE_TOTAL = 1024;
	localparam int ADDR_W     = $clog2(PAGE_TOTAL);
	localparam int PTR_W      = ADDR_W + 1;
	localparam int CNT_W      = 11;
	localparam int START_W    = 10;
	localparam int SUM_W      = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_FREE    = 1'b1;
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_NO_ROOM = 1'b1;

	typedef struct packed {
		logic load;
		logic clear_wr;
		logic scan;
		logic mark_wr;
		logic free_wr;
		logic load_out;
	} ffpa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic free_empty;
		logic alloc_bad;
		logic clear_last;
		logic hit;
		logic miss;
		logic ptr_last;
	} ffpa_sts_t;

endpackage

[sv/ffpa_dp.sv]
// Datapath: page map memory, page pointer, run counter and result registers.
module ffpa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          operation,
	input  logic [ffpa_pkg::CNT_W-1:0]    page_count,
	input  logic [ffpa_pkg::START_W-1:0]  start_page,
	input  ffpa_pkg::ffpa_cmd_t           cmd,
	output ffpa_pkg::ffpa_sts_t           sts,
	output logic                          status,
	output logic [ffpa_pkg::START_W-1:0]  run_start
);
	import ffpa_pkg::*;

	localparam logic [SUM_W-1:0] TOTAL_EXT = SUM_W'(PAGE_TOTAL);

	logic                page_map_q [PAGE_TOTAL];
	logic [PTR_W-1:0]    ptr_q;
	logic [PTR_W-1:0]    end_q;
	logic [PTR_W-1:0]    run_q;
	logic [PTR_W-1:0]    res_start_q;
	logic [CNT_W-1:0]    count_q;
	logic                res_fail_q;
	logic                status_q;
	logic [START_W-1:0]  run_start_q;
	logic                rd_vld_s1;
	logic                rd_data_s1;
	logic [ADDR_W-1:0]   rd_page_s1;

	logic [SUM_W-1:0]    first_ext;
	logic [SUM_W-1:0]    sum_ext;
	logic [SUM_W-1:0]    end_clip;
	logic [PTR_W-1:0]    count_p;
	logic [PTR_W-1:0]    run_inc;
	logic [PTR_W-1:0]    page_next;
	logic [PTR_W-1:0]    hit_start;
	logic                alloc_bad;
	logic                issue_ok;
	logic                hit;
	logic                miss;
	logic                wr_en;
	logic                wr_data;

	always_comb begin
		first_ext = SUM_W'(start_page);
		sum_ext   = first_ext + SUM_W'(page_count);
		end_clip  = (sum_ext > TOTAL_EXT) ? TOTAL_EXT : sum_ext;
		alloc_bad = (page_count == '0) || (SUM_W'(page_count) > TOTAL_EXT);
		count_p   = PTR_W'(count_q);
		run_inc   = run_q + PTR_W'(1);
		page_next = PTR_W'(rd_page_s1) + PTR_W'(1);
		hit_start = page_next - count_p;
		issue_ok  = ptr_q < PTR_W'(PAGE_TOTAL);
		hit       = rd_vld_s1 && !rd_data_s1 && (run_inc == count_p);
		miss      = rd_vld_s1 && !hit && (rd_page_s1 == ADDR_W'(PAGE_TOTAL - 1));
		wr_en     = cmd.clear_wr || cmd.free_wr || cmd.mark_wr;
		wr_data   = cmd.mark_wr;

		sts.is_free    = (operation == OP_FREE);
		sts.free_empty = first_ext >= end_clip;
		sts.alloc_bad  = alloc_bad;
		sts.clear_last = (ptr_q == PTR_W'(PAGE_TOTAL - 1));
		sts.hit        = hit;
		sts.miss       = miss;
		sts.ptr_last   = ((ptr_q + PTR_W'(1)) == end_q);
	end

	// One write and one registered read per cycle, both at the page pointer.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			page_map_q[ptr_q[ADDR_W-1:0]] <= wr_data;
		end
		rd_data_s1 <= page_map_q[ptr_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q <= (operation == OP_FREE) ? PTR_W'(first_ext) : '0;
			end else if (hit) begin
				// rewind to the start of the found run for marking
				ptr_q <= hit_start;
			end else if (wr_en || (cmd.scan && issue_ok)) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			rd_vld_s1 <= cmd.scan && issue_ok && !hit;
		end
	end

	always_ff @(posedge clk) begin
		rd_page_s1 <= ptr_q[ADDR_W-1:0];
		if (cmd.load) begin
			count_q     <= page_count;
			end_q       <= PTR_W'(end_clip);
			run_q       <= '0;
			res_fail_q  <= (operation == OP_ALLOC) && alloc_bad;
			res_start_q <= '0;
		end else begin
			if (rd_vld_s1) begin
				run_q <= rd_data_s1 ? '0 : run_inc;
			end
			if (hit) begin
				end_q       <= page_next;
				res_start_q <= hit_start;
			end
			if (miss) begin
				res_fail_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			status_q    <= res_fail_q ? ST_NO_ROOM : ST_OK;
			run_start_q <= START_W'(res_start_q);
		end
	end

	assign status    = status_q;
	assign run_start = run_start_q;

endmodule

[sv/ffpa_ctrl.sv]
// Controller: sequences clearing, scan, mark, free and result hand-off.
module ffpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ffpa_pkg::ffpa_sts_t  sts,
	output ffpa_pkg::ffpa_cmd_t  cmd
);
	import ffpa_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MARK  = 3'd3;
	localparam logic [2:0] S_FREE  = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.is_free) begin
						state_d = sts.free_empty ? S_RESP : S_FREE;
					end else begin
						state_d = sts.alloc_bad ? S_RESP : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_MARK;
				end else if (sts.miss) begin
					state_d = S_RESP;
				end
			end
			S_MARK: begin
				cmd.mark_wr = 1'b1;
				if (sts.ptr_last) begin
					state_d = S_RESP;
				end
			end
			S_FREE: begin
				cmd.free_wr = 1'b1;
				if (sts.ptr_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				// hold until the output register is empty or being drained
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/first_fit_page_run_allocator.sv]
// First-fit page run allocator: top level joining controller and datapath.
//
// Input channel (in_valid/in_ready): operation, page_count, start_page.
// Allocate (operation 0) finds the lowest start page whose run of page_count
// pages is all free, marks it used and returns status ok with run_start.
// Free (operation 1) clears start_page .. start_page+page_count-1, clipped at
// the last page, and returns status ok with run_start zero.
// Output channel (out_valid/out_ready): status, run_start, one item per input.
// After reset the page map is cleared one page a cycle, all 1024 pages,
// during which in_ready stays low. One item is handled at a time, with a
// one-bit memory port doing one page per cycle. An allocate that finds its
// run at page p scans p + count pages and then marks count pages; a failing
// allocate scans all 1024 pages; a free clears count pages, count clipped at
// the last page; a rejected count (zero or above 1024) goes straight to the
// result.
// The output register lets the next item be accepted while a result waits;
// if the receiver stalls, the block holds the following result, with
// in_ready low, until the register drains.
module first_fit_page_run_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [ffpa_pkg::CNT_W-1:0]    page_count,
	input  logic [ffpa_pkg::START_W-1:0]  start_page,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic [ffpa_pkg::START_W-1:0]  run_start
);
	import ffpa_pkg::*;

	ffpa_cmd_t cmd;
	ffpa_sts_t sts;

	ffpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffpa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (operation),
		.page_count (page_count),
		.start_page (start_page),
		.cmd        (cmd),
		.sts        (sts),
		.status     (status),
		.run_start  (run_start)
	);

`ifndef SYNTHESIS
	a_fail_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NO_ROOM) |-> (run_start == '0))
		else $error("failed allocate returned a nonzero run_start");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block accepted a second item while busy");

	a_one_map_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_wr, cmd.free_wr, cmd.mark_wr, cmd.scan}))
		else $error("more than one page map operation in a cycle");

	a_hit_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.hit && sts.miss))
		else $error("scan reported hit and miss together");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("result loaded over an undelivered item");
`endif

endmodule
